>>> design/fourier_descriptor_normalizer_assert.svh
// Assertion macros for the Fourier descriptor normalizer checker.
// Depends on nothing; included by the checker file.
`ifndef FOURIER_DESCRIPTOR_NORMALIZER_ASSERT_SVH
`define FOURIER_DESCRIPTOR_NORMALIZER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FDN_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define FDN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/fdn_pkg.sv
// Shared constants and controller/datapath interface types for the
// Fourier descriptor normalizer. No dependencies.
package fdn_pkg;

    localparam int NUM_COEFS  = 64;
    localparam int IDX_W      = 12;
    localparam int COEF_W     = 16;
    localparam int DESC_W     = 16;
    localparam int FRAC_W     = 5;
    localparam int FRAC_RESET = 14;
    localparam int MAX_FRAC   = 16;
    localparam int PREC_BITS  = 30;
    localparam int RAD_W      = 32;
    localparam int ROOT_W     = 16;
    localparam int ROOT_ITERS = 16;
    localparam int REM_W      = ROOT_W + 3;
    localparam int FACTOR_W   = PREC_BITS + 1;
    localparam int DIV_ITERS  = FACTOR_W;
    localparam int ITER_W     = 5;
    localparam int SHIFT_W    = 5;

    typedef struct packed {
        logic load;
        logic square;
        logic sum;
        logic root_step;
        logic div_step;
        logic scale_err;
        logic scale_load;
        logic mul;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic idx_zero;
        logic idx_one;
        logic mag_zero;
        logic out_free;
    } t_dp_status;

endpackage

>>> design/fourier_descriptor_normalizer.sv
// Top level of the Fourier descriptor normalizer.
// Depends on fdn_pkg, fdn_ctrl and fdn_datapath.
//
// Coefficients of one contour enter on the input channel (i_in_valid,
// o_in_ready, i_coef_real, i_coef_imag) in index order, 64 per contour.
// Each transfer yields exactly one result on the output channel
// (o_out_valid, i_out_ready) carrying the descriptor, the index, a last
// flag on the final coefficient and a flag for a zero first harmonic.
// The configuration channel (i_cfg_valid, o_cfg_ready, i_cfg_data) sets
// frac_bits; it is always ready. The user must write it only while the
// block idles; the block itself does not enforce this. One item is
// processed at a time. Index 0 goes from the load straight to the output
// load; other indices pass square, sum, the 16-step square root, check and
// product first; index 1 with a nonzero magnitude adds the bit-serial scale
// division. The next item is taken once the result has entered the output
// register, so a result waiting for the receiver does not hold the input.
// When the receiver stalls with a result still pending, the controller
// waits in its done state until the output register frees up.
// Synchronous reset sets frac_bits to 14, the index to 0 and clears scale.
module fourier_descriptor_normalizer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fdn_pkg::FRAC_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [fdn_pkg::COEF_W-1:0] i_coef_real,
    input  logic signed [fdn_pkg::COEF_W-1:0] i_coef_imag,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [fdn_pkg::DESC_W-1:0]        o_descriptor,
    output logic [fdn_pkg::IDX_W-1:0]         o_coef_index,
    output logic                              o_last,
    output logic                              o_zero_scale
);

    fdn_pkg::t_dp_cmd    cmd;
    fdn_pkg::t_dp_status status;

    assign o_cfg_ready = 1'b1;

    fdn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    fdn_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_coef_real  (i_coef_real),
        .i_coef_imag  (i_coef_imag),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_descriptor (o_descriptor),
        .o_coef_index (o_coef_index),
        .o_last       (o_last),
        .o_zero_scale (o_zero_scale)
    );

endmodule

>>> design/fdn_ctrl.sv
// Sequencing state machine of the Fourier descriptor normalizer.
// Depends on fdn_pkg for the command and status types.
module fdn_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  fdn_pkg::t_dp_status i_status,
    output fdn_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQUARE,
        S_SUM,
        S_ROOT,
        S_CHECK,
        S_DIV,
        S_SCALE,
        S_MUL,
        S_DONE
    } t_state;

    t_state                       r_state, n_state;
    logic [fdn_pkg::ITER_W-1:0]   r_iter, n_iter;

    always_comb begin
        n_state = r_state;
        n_iter  = r_iter;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.idx_zero ? S_DONE : S_SQUARE;
                end
            end
            S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_iter    = '0;
                n_state   = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                n_iter          = r_iter + 1'b1;
                if (r_iter == fdn_pkg::ITER_W'(fdn_pkg::ROOT_ITERS - 1)) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_iter = '0;
                if (i_status.idx_one && i_status.mag_zero) begin
                    o_cmd.scale_err = 1'b1;
                    n_state         = S_MUL;
                end else if (i_status.idx_one) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_iter         = r_iter + 1'b1;
                if (r_iter == fdn_pkg::ITER_W'(fdn_pkg::DIV_ITERS - 1)) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                o_cmd.scale_load = 1'b1;
                n_state          = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
        end
    end

endmodule

>>> design/fdn_datapath.sv
// Datapath of the Fourier descriptor normalizer: squares, square root,
// scale division, product, shift and output register. Depends on fdn_pkg.
module fdn_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [fdn_pkg::FRAC_W-1:0]        i_cfg_data,
    input  logic signed [fdn_pkg::COEF_W-1:0] i_coef_real,
    input  logic signed [fdn_pkg::COEF_W-1:0] i_coef_imag,
    input  fdn_pkg::t_dp_cmd                  i_cmd,
    output fdn_pkg::t_dp_status               o_status,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [fdn_pkg::DESC_W-1:0]        o_descriptor,
    output logic [fdn_pkg::IDX_W-1:0]         o_coef_index,
    output logic                              o_last,
    output logic                              o_zero_scale
);

    localparam int DVD_W = fdn_pkg::PREC_BITS + 1;
    localparam int PROD_W = fdn_pkg::ROOT_W + fdn_pkg::FACTOR_W;

    logic [fdn_pkg::FRAC_W-1:0]   r_frac;
    logic [fdn_pkg::IDX_W-1:0]    r_idx;
    logic [fdn_pkg::FACTOR_W-1:0] r_factor;
    logic                         r_err;
    logic                         r_out_valid;

    logic [fdn_pkg::COEF_W-1:0]   r_ar, r_ai;
    logic [fdn_pkg::RAD_W-1:0]    r_sq_re, r_sq_im, r_rad;
    logic [fdn_pkg::REM_W-1:0]    r_rem;
    logic [fdn_pkg::ROOT_W-1:0]   r_root;
    logic [fdn_pkg::ROOT_W-1:0]   r_drem;
    logic [DVD_W-1:0]             r_dvd;
    logic [fdn_pkg::FACTOR_W-1:0] r_quot;
    logic [fdn_pkg::RAD_W-1:0]    r_prod;
    logic [fdn_pkg::DESC_W-1:0]   r_desc;
    logic [fdn_pkg::IDX_W-1:0]    r_out_idx;
    logic                         r_last;
    logic                         r_zs;

    logic [fdn_pkg::COEF_W-1:0]   abs_re, abs_im;
    logic [fdn_pkg::REM_W-1:0]    rem_shift, trial;
    logic                         root_ok;
    logic [fdn_pkg::ROOT_W:0]     div_try;
    logic                         div_ok;
    logic [PROD_W-1:0]            prod_full;
    logic [fdn_pkg::FRAC_W-1:0]   frac_sat;
    logic [fdn_pkg::SHIFT_W-1:0]  shift_amt;
    logic [fdn_pkg::RAD_W-1:0]    shifted;
    logic                         idx_last;

    assign abs_re = i_coef_real[fdn_pkg::COEF_W-1] ? (~i_coef_real + 1'b1) : i_coef_real;
    assign abs_im = i_coef_imag[fdn_pkg::COEF_W-1] ? (~i_coef_imag + 1'b1) : i_coef_imag;

    assign rem_shift = {r_rem[fdn_pkg::REM_W-3:0], r_rad[fdn_pkg::RAD_W-1 -: 2]};
    assign trial     = {1'b0, r_root, 2'b01};
    assign root_ok   = (trial <= rem_shift);

    assign div_try = {r_drem, r_dvd[DVD_W-1]};
    assign div_ok  = (div_try >= {1'b0, r_root});

    assign prod_full = PROD_W'(r_root) * PROD_W'(r_factor);

    assign frac_sat  = (r_frac > fdn_pkg::FRAC_W'(fdn_pkg::MAX_FRAC))
                       ? fdn_pkg::FRAC_W'(fdn_pkg::MAX_FRAC) : r_frac;
    assign shift_amt = fdn_pkg::SHIFT_W'(fdn_pkg::PREC_BITS) - fdn_pkg::SHIFT_W'(frac_sat);
    assign shifted   = r_prod >> shift_amt;

    assign idx_last = (r_idx == fdn_pkg::IDX_W'(fdn_pkg::NUM_COEFS - 1));

    assign o_status.idx_zero = (r_idx == '0);
    assign o_status.idx_one  = (r_idx == fdn_pkg::IDX_W'(1));
    assign o_status.mag_zero = (r_root == '0);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac      <= fdn_pkg::FRAC_W'(fdn_pkg::FRAC_RESET);
            r_idx       <= '0;
            r_factor    <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_frac <= i_cfg_data;
            end
            if (i_cmd.load && (r_idx == '0)) begin
                r_factor <= '0;
                r_err    <= 1'b0;
            end else if (i_cmd.scale_err) begin
                r_factor <= '0;
                r_err    <= 1'b1;
            end else if (i_cmd.scale_load) begin
                r_factor <= r_quot;
            end
            if (i_cmd.out_load) begin
                r_idx       <= idx_last ? '0 : r_idx + 1'b1;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ar <= abs_re;
            r_ai <= abs_im;
        end
        if (i_cmd.square) begin
            r_sq_re <= fdn_pkg::RAD_W'(r_ar) * fdn_pkg::RAD_W'(r_ar);
            r_sq_im <= fdn_pkg::RAD_W'(r_ai) * fdn_pkg::RAD_W'(r_ai);
        end
        if (i_cmd.sum) begin
            r_rad  <= r_sq_re + r_sq_im;
            r_rem  <= '0;
            r_root <= '0;
            r_drem <= '0;
            r_quot <= '0;
            r_dvd  <= DVD_W'(1) << fdn_pkg::PREC_BITS;
        end
        if (i_cmd.root_step) begin
            r_rad  <= r_rad << 2;
            r_rem  <= root_ok ? (rem_shift - trial) : rem_shift;
            r_root <= {r_root[fdn_pkg::ROOT_W-2:0], root_ok};
        end
        if (i_cmd.div_step) begin
            r_dvd  <= r_dvd << 1;
            r_drem <= div_ok ? fdn_pkg::ROOT_W'(div_try - {1'b0, r_root})
                             : div_try[fdn_pkg::ROOT_W-1:0];
            r_quot <= {r_quot[fdn_pkg::FACTOR_W-2:0], div_ok};
        end
        if (i_cmd.mul) begin
            r_prod <= prod_full[fdn_pkg::RAD_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_out_idx <= r_idx;
            r_last    <= idx_last;
            if (r_idx == '0) begin
                r_desc <= '0;
                r_zs   <= 1'b0;
            end else begin
                r_desc <= r_err ? '0 : shifted[fdn_pkg::DESC_W-1:0];
                r_zs   <= r_err;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_descriptor = r_desc;
    assign o_coef_index = r_out_idx;
    assign o_last       = r_last;
    assign o_zero_scale = r_zs;

endmodule

>>> design/fdn_checker.sv
// Port-level checker for the Fourier descriptor normalizer and its bind.
// Depends on fdn_pkg and fourier_descriptor_normalizer_assert.svh.
`include "fourier_descriptor_normalizer_assert.svh"

module fdn_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic [fdn_pkg::DESC_W-1:0] o_descriptor,
    input logic [fdn_pkg::IDX_W-1:0]  o_coef_index,
    input logic                       o_last,
    input logic                       o_zero_scale
);

    `FDN_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_descriptor) && $stable(o_coef_index),
        "Output result changed while stalled.")

    `FDN_ASSERT_NOW(a_index_zero, i_clk, i_rst_n,
        o_out_valid && (o_coef_index == '0),
        (o_descriptor == '0) && !o_zero_scale,
        "Index zero result is not a zero descriptor.")

    `FDN_ASSERT_NOW(a_zero_scale, i_clk, i_rst_n,
        o_out_valid && o_zero_scale,
        o_descriptor == '0,
        "Zero scale result carries a nonzero descriptor.")

    `FDN_ASSERT_NOW(a_last_flag, i_clk, i_rst_n,
        o_out_valid,
        o_last == (o_coef_index == fdn_pkg::IDX_W'(fdn_pkg::NUM_COEFS - 1)),
        "Last flag does not match the final index.")

endmodule

bind fourier_descriptor_normalizer fdn_checker u_fdn_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_descriptor (o_descriptor),
    .o_coef_index (o_coef_index),
    .o_last       (o_last),
    .o_zero_scale (o_zero_scale)
);
